// ----- hdl/tct_pkg.sv -----
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants of the touch contact slot tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

    // fixed field widths
    localparam int KIND_W     = 2;
    localparam int RAW_W      = 12;
    localparam int ISCALE_W   = 13;
    localparam int HEIGHT_W   = 14;
    localparam int POINT_X_W  = 13;
    localparam int POINT_Y_W  = 14;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 4;
    localparam int FRAC_BITS  = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    // event codes
    localparam logic [KIND_W-1:0] ACT_DOWN   = 2'd0;
    localparam logic [KIND_W-1:0] ACT_UP     = 2'd1;
    localparam logic [KIND_W-1:0] ACT_MOVE   = 2'd2;
    localparam logic [KIND_W-1:0] ACT_RESUME = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_HEIGHT = 1'd1;

    // register reset values
    localparam logic [ISCALE_W-1:0] INV_SCALE_RESET = 13'd4096;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 14'd4096;

    // saturation limits
    localparam logic [POINT_X_W-1:0] POINT_X_MAX = 13'd8191;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCALE_X,
        ST_SCALE_Y,
        ST_LOAD
    } state_t;

    // slot table write command
    typedef struct packed {
        logic clear_all;
        logic wr_en;
        logic set_held;
        logic clr_held;
    } slot_ctl_t;

endpackage

// ----- hdl/tct_if.sv -----
// ----------------------------------------------------------------------------
// tct_if
// Valid/ready channels for event items in and result items out.
// ----------------------------------------------------------------------------
interface tct_in_if
    import tct_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   action;
    logic [RAW_W-1:0]    raw_x;
    logic [RAW_W-1:0]    raw_y;

    modport source (output valid, action, raw_x, raw_y, input ready);
    modport sink   (input valid, action, raw_x, raw_y, output ready);
endinterface

interface tct_out_if
    import tct_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           event_kind;
    logic [POINT_X_W-1:0]        point_x;
    logic signed [POINT_Y_W-1:0] point_y;
    logic [IDX_W-1:0]            slot_index;
    logic [CNT_W-1:0]            contact_count;

    modport source (output valid, event_kind, point_x, point_y, slot_index, contact_count,
                    input ready);
    modport sink   (input valid, event_kind, point_x, point_y, slot_index, contact_count,
                    output ready);
endinterface

// ----- hdl/tct_mul_unit.sv -----
// ----------------------------------------------------------------------------
// tct_mul_unit
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tct_mul_unit
    import tct_pkg::*;
#(
    parameter int MW = 13
) (
    input  logic            clk,
    input  logic [MW-1:0]   a,
    input  logic [MW-1:0]   b,
    output logic [2*MW-1:0] p
);

    logic [2*MW-1:0] p_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- hdl/tct_slot_table.sv -----
// ----------------------------------------------------------------------------
// tct_slot_table
// Held bits and last positions of the contact slots.
// ----------------------------------------------------------------------------
module tct_slot_table
    import tct_pkg::*;
#(
    parameter int SLOTS = 10,
    parameter int CW    = 12,
    parameter int SW    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  slot_ctl_t        ctl,
    input  logic [SW-1:0]    wr_idx,
    input  logic [CW-1:0]    wr_x,
    input  logic [CW-1:0]    wr_y,
    input  logic [SW-1:0]    rd_idx,
    output logic [SLOTS-1:0] held,
    output logic [CW-1:0]    rd_x,
    output logic [CW-1:0]    rd_y
);

    logic [SLOTS-1:0] held_reg;
    logic [CW-1:0]    pos_x_reg [SLOTS];
    logic [CW-1:0]    pos_y_reg [SLOTS];

    // held bits: cleared together on a pending clear, else set or freed one at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (ctl.clear_all)
        begin
            held_reg <= '0;
        end
        else if (ctl.wr_en && ctl.set_held)
        begin
            held_reg[wr_idx] <= 1'b1;
        end
        else if (ctl.wr_en && ctl.clr_held)
        begin
            held_reg[wr_idx] <= 1'b0;
        end
    end

    // positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                pos_x_reg[i] <= '0;
                pos_y_reg[i] <= '0;
            end
        end
        else if (ctl.wr_en)
        begin
            pos_x_reg[wr_idx] <= wr_x;
            pos_y_reg[wr_idx] <= wr_y;
        end
    end

    assign held = held_reg;
    assign rd_x = pos_x_reg[rd_idx];
    assign rd_y = pos_y_reg[rd_idx];

endmodule

// ----- hdl/tct_out_stage.sv -----
// ----------------------------------------------------------------------------
// tct_out_stage
// Scales, saturates and flips the point and holds the result item.
// ----------------------------------------------------------------------------
module tct_out_stage
    import tct_pkg::*;
#(
    parameter int MW = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [KIND_W-1:0]    kind,
    input  logic [2*MW-1:0]      prod_x,
    input  logic [2*MW-1:0]      prod_y,
    input  logic [HEIGHT_W-1:0]  height,
    input  logic [IDX_W-1:0]     slot_idx,
    input  logic [CNT_W-1:0]     count,
    output logic                 free,
    tct_out_if.source            res
);

    localparam int SAT_LSB = FRAC_BITS + POINT_X_W;
    localparam int FLIP_W  = HEIGHT_W + 2;

    logic                        valid_reg;
    logic [KIND_W-1:0]           kind_reg;
    logic [POINT_X_W-1:0]        px_reg;
    logic signed [POINT_Y_W-1:0] py_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            cnt_reg;

    logic [POINT_X_W-1:0]        sx;
    logic [POINT_X_W-1:0]        sy;
    logic signed [FLIP_W-1:0]    flip;
    logic signed [POINT_Y_W-1:0] py;

    // drop the fraction and saturate the scaled coordinates
    always_comb
    begin
        sx = (|prod_x[2*MW-1:SAT_LSB]) ? POINT_X_MAX : prod_x[SAT_LSB-1:FRAC_BITS];
        sy = (|prod_y[2*MW-1:SAT_LSB]) ? POINT_X_MAX : prod_y[SAT_LSB-1:FRAC_BITS];
    end

    // flip y against the layout height and clamp to the signed field
    always_comb
    begin
        flip = $signed({2'b00, height}) - $signed(FLIP_W'(1))
               - $signed({{(FLIP_W-POINT_X_W){1'b0}}, sy});
        if (flip > $signed(FLIP_W'(8191)))
        begin
            py = 14'sd8191;
        end
        else if (flip < -$signed(FLIP_W'(8192)))
        begin
            py = -14'sd8192;
        end
        else
        begin
            py = flip[POINT_Y_W-1:0];
        end
    end

    assign free = !valid_reg || res.ready;

    // output handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind;
            px_reg   <= sx;
            py_reg   <= py;
            idx_reg  <= slot_idx;
            cnt_reg  <= count;
        end
    end

    assign res.valid         = valid_reg;
    assign res.event_kind    = kind_reg;
    assign res.point_x       = px_reg;
    assign res.point_y       = py_reg;
    assign res.slot_index    = idx_reg;
    assign res.contact_count = cnt_reg;

    // a new item only lands in a free register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n) load |-> free)
        else $error("result loaded over a waiting item");

    // a waiting item is not dropped
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid)
        else $error("waiting result lost");

    // y stays inside the signed range after the clamp
    a_py_range: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (py <= 14'sd8191))
        else $error("flipped y out of range");

endmodule

// ----- hdl/touch_contact_slot_tracker_core.sv -----
// ----------------------------------------------------------------------------
// touch_contact_slot_tracker_core
// Touch contact slot tracker: assigns down events to free slots and matches
// up and move events to the nearest held slot.
// ----------------------------------------------------------------------------
// Usage
//   evt carries event items (action, raw_x, raw_y) on valid/ready; res carries
//   result items (event_kind, point_x, point_y, slot_index, contact_count).
//   cfg_we/cfg_index/cfg_wdata write inverse_scale (index 0) and
//   layout_height (index 1); write them only while the block is idle.
//   One item is worked on at a time; evt.ready is high only when idle.
//   A resume item gives no result; the block stays idle.
//   Down, up and move items scan the slot table with the one shared
//   multiplier: two products (dx squared, dy squared) per slot, then two
//   more for the scaled x and y, and then the result is loaded. Down items
//   with a full table and up or move items with no held slot give no result.
//   A finished result waits in the output register; if res stalls, the
//   block holds in its last step until the register frees, and accepts the
//   next item once the result has moved in.
//   Reset empties every slot, drops a pending clear, sets inverse_scale and
//   layout_height to 4096 and empties the output register.
// ----------------------------------------------------------------------------
module touch_contact_slot_tracker_core
    import tct_pkg::*;
#(
    parameter int SLOTS      = 10,
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tct_in_if.sink                evt,
    tct_out_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW   = COORD_BITS;
    localparam int MW   = (CW > ISCALE_W) ? CW : ISCALE_W;
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int DW   = 2 * CW + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    // configuration
    logic [ISCALE_W-1:0] inv_scale_reg;
    logic [HEIGHT_W-1:0] height_reg;

    // sequencer state
    state_t              state_reg, state_next;
    logic                clear_pending_reg, clear_pending_next;
    logic [KIND_W-1:0]   act_reg, act_next;
    logic [CW-1:0]       x_reg, x_next;
    logic [CW-1:0]       y_reg, y_next;
    logic [SW-1:0]       issue_idx_reg, issue_idx_next;
    logic                phase_reg, phase_next;
    logic                issue_done_reg, issue_done_next;
    logic                prev_valid_reg, prev_valid_next;
    logic                prev_phase_reg, prev_phase_next;
    logic [SW-1:0]       prev_idx_reg, prev_idx_next;
    logic [2*CW-1:0]     acc_reg, acc_next;
    logic [DW-1:0]       best_d_reg, best_d_next;
    logic [SW-1:0]       best_idx_reg, best_idx_next;
    logic                found_reg, found_next;
    logic [SW-1:0]       free_idx_reg, free_idx_next;
    logic                free_found_reg, free_found_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [2*MW-1:0]     sx_reg, sx_next;

    // datapath
    logic                accept;
    logic [MW-1:0]       mul_a;
    logic [MW-1:0]       mul_b;
    logic [2*MW-1:0]     prod;
    logic [CW-1:0]       diff;
    logic [DW-1:0]       slot_dist;
    logic                hit;
    logic [CNTW:0]       rep_cnt;
    slot_ctl_t           ctl;
    logic [SW-1:0]       wr_idx;
    logic [SLOTS-1:0]    held;
    logic [CW-1:0]       rd_x;
    logic [CW-1:0]       rd_y;
    logic                out_free;
    logic                load;

    assign evt.ready = (state_reg == ST_IDLE);
    assign accept    = evt.valid && evt.ready;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_reg <= INV_SCALE_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INV_SCALE:     inv_scale_reg <= cfg_wdata[ISCALE_W-1:0];
                CFG_LAYOUT_HEIGHT: height_reg    <= cfg_wdata[HEIGHT_W-1:0];
                default:           ;
            endcase
        end
    end

    // shared multiplier
    tct_mul_unit #(
        .MW (MW)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // slot table
    tct_slot_table #(
        .SLOTS (SLOTS),
        .CW    (CW),
        .SW    (SW)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .wr_idx (wr_idx),
        .wr_x   (x_reg),
        .wr_y   (y_reg),
        .rd_idx (issue_idx_reg),
        .held   (held),
        .rd_x   (rd_x),
        .rd_y   (rd_y)
    );

    // difference for the slot being issued and distance of the slot finishing this cycle
    assign diff = phase_reg ? ((rd_y > y_reg) ? rd_y - y_reg : y_reg - rd_y)
                            : ((rd_x > x_reg) ? rd_x - x_reg : x_reg - rd_x);
    assign slot_dist = {1'b0, acc_reg} + {1'b0, prod[2*CW-1:0]};

    assign hit     = (act_reg == ACT_DOWN) ? free_found_reg : found_reg;
    assign wr_idx  = (act_reg == ACT_DOWN) ? free_idx_reg : best_idx_reg;
    assign rep_cnt = (act_reg == ACT_DOWN) ? {1'b0, cnt_reg} + (CNTW + 1)'(1)
                                           : {1'b0, cnt_reg};

    // output register and point formatting
    tct_out_stage #(
        .MW (MW)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .kind     (act_reg),
        .prod_x   (sx_reg),
        .prod_y   (prod),
        .height   (height_reg),
        .slot_idx (IDX_W'(wr_idx)),
        .count    (CNT_W'(rep_cnt)),
        .free     (out_free),
        .res      (res)
    );

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            clear_pending_reg <= 1'b0;
            issue_idx_reg     <= '0;
            phase_reg         <= 1'b0;
            issue_done_reg    <= 1'b0;
            prev_valid_reg    <= 1'b0;
            found_reg         <= 1'b0;
            free_found_reg    <= 1'b0;
            cnt_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            clear_pending_reg <= clear_pending_next;
            issue_idx_reg     <= issue_idx_next;
            phase_reg         <= phase_next;
            issue_done_reg    <= issue_done_next;
            prev_valid_reg    <= prev_valid_next;
            found_reg         <= found_next;
            free_found_reg    <= free_found_next;
            cnt_reg           <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        prev_phase_reg <= prev_phase_next;
        prev_idx_reg   <= prev_idx_next;
        acc_reg        <= acc_next;
        best_d_reg     <= best_d_next;
        best_idx_reg   <= best_idx_next;
        free_idx_reg   <= free_idx_next;
        sx_reg         <= sx_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next         = state_reg;
        clear_pending_next = clear_pending_reg;
        act_next           = act_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        issue_idx_next     = issue_idx_reg;
        phase_next         = phase_reg;
        issue_done_next    = issue_done_reg;
        prev_valid_next    = 1'b0;
        prev_phase_next    = prev_phase_reg;
        prev_idx_next      = prev_idx_reg;
        acc_next           = acc_reg;
        best_d_next        = best_d_reg;
        best_idx_next      = best_idx_reg;
        found_next         = found_reg;
        free_idx_next      = free_idx_reg;
        free_found_next    = free_found_reg;
        cnt_next           = cnt_reg;
        sx_next            = sx_reg;
        ctl                = '0;
        load               = 1'b0;
        mul_a              = MW'(y_reg);
        mul_b              = MW'(inv_scale_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next = evt.action;
                    x_next   = CW'(evt.raw_x);
                    y_next   = CW'(evt.raw_y);
                    if (evt.action == ACT_RESUME)
                    begin
                        clear_pending_next = 1'b1;
                    end
                    else
                    begin
                        if (evt.action == ACT_DOWN && clear_pending_reg)
                        begin
                            ctl.clear_all      = 1'b1;
                            clear_pending_next = 1'b0;
                        end
                        issue_idx_next  = '0;
                        phase_next      = 1'b0;
                        issue_done_next = 1'b0;
                        found_next      = 1'b0;
                        free_found_next = 1'b0;
                        cnt_next        = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue dx squared then dy squared for each slot
                mul_a = MW'(diff);
                mul_b = MW'(diff);
                if (!issue_done_reg)
                begin
                    prev_valid_next = 1'b1;
                    prev_phase_next = phase_reg;
                    prev_idx_next   = issue_idx_reg;
                    phase_next      = !phase_reg;
                    if (phase_reg)
                    begin
                        if (issue_idx_reg == LAST_SLOT)
                        begin
                            issue_done_next = 1'b1;
                        end
                        else
                        begin
                            issue_idx_next = issue_idx_reg + SW'(1);
                        end
                    end
                end

                // finish the slot whose products are back
                if (prev_valid_reg)
                begin
                    if (!prev_phase_reg)
                    begin
                        acc_next = prod[2*CW-1:0];
                    end
                    else if (held[prev_idx_reg])
                    begin
                        cnt_next = cnt_reg + CNTW'(1);
                        if (!found_reg || slot_dist < best_d_reg)
                        begin
                            found_next    = 1'b1;
                            best_idx_next = prev_idx_reg;
                            best_d_next   = slot_dist;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = prev_idx_reg;
                    end
                end

                if (issue_done_reg && !prev_valid_reg)
                begin
                    state_next = hit ? ST_SCALE_X : ST_IDLE;
                end
            end

            ST_SCALE_X:
            begin
                mul_a      = MW'(x_reg);
                state_next = ST_SCALE_Y;
            end

            ST_SCALE_Y:
            begin
                sx_next    = prod;
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                // y product stays in the multiplier until the output frees
                if (out_free)
                begin
                    load         = 1'b1;
                    ctl.wr_en    = 1'b1;
                    ctl.set_held = (act_reg == ACT_DOWN);
                    ctl.clr_held = (act_reg == ACT_UP);
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a down item always takes a slot that was free
    a_down_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load && act_reg == ACT_DOWN) |-> !held[free_idx_reg])
        else $error("down item placed in a held slot");

    // up and move items only touch a held slot
    a_match_held: assert property (@(posedge clk) disable iff (!rst_n)
        (load && act_reg != ACT_DOWN) |-> held[best_idx_reg])
        else $error("up or move matched a free slot");

    // the held count never passes the table size
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(SLOTS))
        else $error("held count beyond table size");

    // a resume item arms the pending clear
    a_resume_arm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && evt.action == ACT_RESUME) |=> clear_pending_reg)
        else $error("resume did not arm the clear");

    // the scan stops on a whole slot
    a_scan_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && issue_done_reg) |-> !phase_reg)
        else $error("scan stopped mid slot");

endmodule
